FILE: rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned DATA_BITS    = 8;
    localparam int unsigned PERIOD_W     = 5;
    localparam int unsigned HOLD_W       = 16;
    localparam int unsigned BYTE_PERIODS = 2 * DATA_BITS + 2;
    localparam int unsigned CTRL_PERIODS = 2;

    // Input item kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    typedef enum logic [4:0] {
        CMD_IDLE  = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP  = 5'b00100,
        CMD_WRITE = 5'b01000,
        CMD_READ  = 5'b10000
    } cmd_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_level;
    } item_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [PERIOD_W-1:0]  period;
        logic [HOLD_W-1:0]    ticks;
        logic [DATA_BITS-1:0] shift;
        logic                 ack_flag;
        logic                 master_ack;
        logic                 scl;
        logic                 sda;
    } engine_t;

    typedef struct packed {
        logic                 scl_release;
        logic                 sda_release;
        logic                 busy_res;
        logic                 done_res;
        logic                 ack_seen;
        logic [DATA_BITS-1:0] read_byte;
        logic                 refused;
    } result_t;

    // Line levels for a given period of a command: {scl, sda}
    function automatic logic [1:0] drive_lines(
        input cmd_t                 cmd,
        input logic [PERIOD_W-1:0]  p,
        input logic [DATA_BITS-1:0] shift,
        input logic                 mack,
        input logic                 scl_now,
        input logic                 sda_now
    );
        logic scl_v;
        logic sda_v;
        logic data_phase;
        scl_v      = scl_now;
        sda_v      = sda_now;
        data_phase = (p < PERIOD_W'(2 * DATA_BITS));
        unique case (cmd)
            CMD_START:
            begin
                scl_v = 1'b1;
                sda_v = (p == '0);
            end
            CMD_STOP:
            begin
                scl_v = 1'b1;
                sda_v = (p != '0);
            end
            CMD_WRITE:
            begin
                scl_v = ~p[0];
                sda_v = data_phase ? shift[DATA_BITS-1] : 1'b1;
            end
            CMD_READ:
            begin
                scl_v = ~p[0];
                sda_v = data_phase ? 1'b1 : ~mack;
            end
            default:
            begin
                scl_v = scl_now;
                sda_v = sda_now;
            end
        endcase
        return {scl_v, sda_v};
    endfunction

endpackage

FILE: rtl/core/i2cm_step.sv
`timescale 1ns / 1ps

// Next engine state and result for one item, from the current state.
module i2cm_step (
    input  i2cm_pkg::item_t                    item,
    input  i2cm_pkg::engine_t                  cur,
    input  logic [i2cm_pkg::HOLD_W-1:0]        hold_ticks,
    output i2cm_pkg::engine_t                  nxt,
    output i2cm_pkg::result_t                  res
);

    logic [i2cm_pkg::HOLD_W:0]     tick_inc;
    logic [i2cm_pkg::HOLD_W-1:0]   hold_eff;
    logic [i2cm_pkg::PERIOD_W-1:0] p_inc;
    logic [i2cm_pkg::PERIOD_W-1:0] total;
    logic [1:0]                    lines;
    logic                          done;
    logic                          refused;
    logic                          ack_out;
    logic [i2cm_pkg::DATA_BITS-1:0] byte_out;

    always_comb
    begin
        nxt      = cur;
        done     = 1'b0;
        refused  = 1'b0;
        ack_out  = 1'b0;
        byte_out = '0;
        lines    = 2'b11;
        hold_eff = (hold_ticks == '0) ? i2cm_pkg::HOLD_W'(1) : hold_ticks;
        tick_inc = {1'b0, cur.ticks} + (i2cm_pkg::HOLD_W + 1)'(1);
        p_inc    = cur.period + i2cm_pkg::PERIOD_W'(1);
        total    = ((cur.cmd == i2cm_pkg::CMD_START) || (cur.cmd == i2cm_pkg::CMD_STOP))
                   ? i2cm_pkg::PERIOD_W'(i2cm_pkg::CTRL_PERIODS)
                   : i2cm_pkg::PERIOD_W'(i2cm_pkg::BYTE_PERIODS);

        case (item.kind) inside
            i2cm_pkg::KIND_START, i2cm_pkg::KIND_STOP,
            i2cm_pkg::KIND_WRITE, i2cm_pkg::KIND_READ:
            begin
                if (cur.cmd != i2cm_pkg::CMD_IDLE)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    nxt.period = '0;
                    nxt.ticks  = '0;
                    unique case (item.kind)
                        i2cm_pkg::KIND_START: nxt.cmd = i2cm_pkg::CMD_START;
                        i2cm_pkg::KIND_STOP:  nxt.cmd = i2cm_pkg::CMD_STOP;
                        i2cm_pkg::KIND_WRITE:
                        begin
                            nxt.cmd      = i2cm_pkg::CMD_WRITE;
                            nxt.shift    = item.tx_byte;
                            nxt.ack_flag = 1'b0;
                        end
                        default:
                        begin
                            nxt.cmd        = i2cm_pkg::CMD_READ;
                            nxt.shift      = '0;
                            nxt.master_ack = item.send_ack;
                        end
                    endcase
                    lines   = i2cm_pkg::drive_lines(nxt.cmd, '0, nxt.shift,
                                                    nxt.master_ack, cur.scl, cur.sda);
                    nxt.scl = lines[1];
                    nxt.sda = lines[0];
                end
            end
            i2cm_pkg::KIND_TICK:
            begin
                if (cur.cmd != i2cm_pkg::CMD_IDLE)
                begin
                    if (tick_inc >= {1'b0, hold_eff})
                    begin
                        nxt.ticks = '0;
                        // advance one period; data moves on its period boundary
                        if (cur.cmd == i2cm_pkg::CMD_WRITE)
                        begin
                            if ((cur.period < i2cm_pkg::PERIOD_W'(2 * i2cm_pkg::DATA_BITS))
                                && cur.period[0])
                                nxt.shift = {cur.shift[i2cm_pkg::DATA_BITS-2:0], 1'b0};
                            if (cur.period == i2cm_pkg::PERIOD_W'(2 * i2cm_pkg::DATA_BITS))
                                nxt.ack_flag = ~item.sda_level;
                        end
                        else if (cur.cmd == i2cm_pkg::CMD_READ)
                        begin
                            if ((cur.period < i2cm_pkg::PERIOD_W'(2 * i2cm_pkg::DATA_BITS))
                                && !cur.period[0])
                                nxt.shift = {cur.shift[i2cm_pkg::DATA_BITS-2:0],
                                             item.sda_level};
                        end

                        if (p_inc >= total)
                        begin
                            done       = 1'b1;
                            nxt.cmd    = i2cm_pkg::CMD_IDLE;
                            nxt.period = '0;
                            if (cur.cmd == i2cm_pkg::CMD_START)
                            begin
                                nxt.scl = 1'b0;
                                nxt.sda = 1'b0;
                            end
                            else if (cur.cmd == i2cm_pkg::CMD_STOP)
                            begin
                                nxt.scl = 1'b1;
                                nxt.sda = 1'b1;
                            end
                            else
                            begin
                                nxt.scl = 1'b0;
                                if (cur.cmd == i2cm_pkg::CMD_WRITE)
                                    ack_out = nxt.ack_flag;
                                else
                                    byte_out = nxt.shift;
                            end
                        end
                        else
                        begin
                            nxt.period = p_inc;
                            lines      = i2cm_pkg::drive_lines(cur.cmd, p_inc, nxt.shift,
                                                               cur.master_ack, cur.scl,
                                                               cur.sda);
                            nxt.scl    = lines[1];
                            nxt.sda    = lines[0];
                        end
                    end
                    else
                    begin
                        nxt.ticks = tick_inc[i2cm_pkg::HOLD_W-1:0];
                    end
                end
            end
            default:
            begin
                // unused kinds: no effect
            end
        endcase

        res.scl_release = nxt.scl;
        res.sda_release = nxt.sda;
        res.busy_res    = (nxt.cmd != i2cm_pkg::CMD_IDLE);
        res.done_res    = done;
        res.ack_seen    = ack_out;
        res.read_byte   = byte_out;
        res.refused     = refused;
    end

endmodule

FILE: rtl/core/i2c_master_bit_engine.sv
`timescale 1ns / 1ps

// Open-drain I2C master bit engine. Each input transaction is a command (start, stop,
// write byte, read byte) or a time tick carrying the sampled SDA level, and each one
// yields exactly one result transaction with the line controls and status. An item
// passes through the input register and then the result register, and one item is
// taken every clock while results are drained; the combinational state update
// between those two registers sets that rate. A delay period lasts hold_ticks tick
// items (zero acts as one); start and stop span two periods, a byte eighteen.
// Commands arriving while busy are flagged refused and otherwise ignored. The
// hold_ticks register is written through the cfg channel, which is always ready;
// write it only while no transaction is in flight.
module i2c_master_bit_engine (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         kind,
    input  logic [i2cm_pkg::DATA_BITS-1:0]     tx_byte,
    input  logic                               send_ack,
    input  logic                               sda_level,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               scl_release,
    output logic                               sda_release,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               ack_seen,
    output logic [i2cm_pkg::DATA_BITS-1:0]     read_byte,
    output logic                               refused,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cm_pkg::HOLD_W-1:0]        cfg_data
);

    logic                         s1_valid_reg;
    i2cm_pkg::item_t              s1_item_reg;
    logic                         out_valid_reg;
    i2cm_pkg::result_t            out_res_reg;
    i2cm_pkg::engine_t            state_reg;
    i2cm_pkg::engine_t            state_next;
    i2cm_pkg::result_t            res_next;
    logic [i2cm_pkg::HOLD_W-1:0]  hold_reg;
    logic                         advance;
    i2cm_pkg::item_t              in_item;

    assign in_item.kind      = kind;
    assign in_item.tx_byte   = tx_byte;
    assign in_item.send_ack  = send_ack;
    assign in_item.sda_level = sda_level;

    // move the held item into the result register when that register is free
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    i2cm_step u_step (
        .item       (s1_item_reg),
        .cur        (state_reg),
        .hold_ticks (hold_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            hold_reg             <= i2cm_pkg::HOLD_W'(1);
            state_reg.cmd        <= i2cm_pkg::CMD_IDLE;
            state_reg.period     <= '0;
            state_reg.ticks      <= '0;
            state_reg.shift      <= '0;
            state_reg.ack_flag   <= 1'b0;
            state_reg.master_ack <= 1'b0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                hold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_item;
        if (advance)
            out_res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = out_res_reg.scl_release;
    assign sda_release = out_res_reg.sda_release;
    assign busy_res    = out_res_reg.busy_res;
    assign done_res    = out_res_reg.done_res;
    assign ack_seen    = out_res_reg.ack_seen;
    assign read_byte   = out_res_reg.read_byte;
    assign refused     = out_res_reg.refused;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.done_res |-> !out_res_reg.busy_res)
        else $error("done reported while still busy");

    a_ack_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.ack_seen |-> out_res_reg.done_res)
        else $error("ack_seen outside a finishing item");

    a_byte_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.read_byte != '0) |-> out_res_reg.done_res)
        else $error("read_byte outside a finishing item");

    a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.refused |=> state_reg == $past(state_reg))
        else $error("refused command changed engine state");

    a_refused_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.refused |-> state_reg.cmd != i2cm_pkg::CMD_IDLE)
        else $error("command refused while idle");

endmodule

FILE: test/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;

    localparam logic [2:0]  KIND_SPARE    = 3'd5;
    localparam logic [2:0]  KIND_LAST     = 3'd7;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned PRINT_CAP     = 40;
    localparam int unsigned LONG_TICKS    = 40;
    localparam logic [15:0] HOLD_MAX      = 16'hFFFF;

    typedef struct {
        i2cm_pkg::item_t it;
        logic            is_cfg;
        logic [15:0]     cfg_val;
        logic            dense;
    } job_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [2:0]                     kind      = i2cm_pkg::KIND_TICK;
    logic [i2cm_pkg::DATA_BITS-1:0] tx_byte   = '0;
    logic                           send_ack  = 1'b0;
    logic                           sda_level = 1'b0;

    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic                           scl_release;
    logic                           sda_release;
    logic                           busy_res;
    logic                           done_res;
    logic                           ack_seen;
    logic [i2cm_pkg::DATA_BITS-1:0] read_byte;
    logic                           refused;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [i2cm_pkg::HOLD_W-1:0]    cfg_data  = '0;

    // engine model
    i2cm_pkg::cmd_t                 m_cmd;
    logic [i2cm_pkg::PERIOD_W-1:0]  m_period;
    int unsigned                    m_ticks;
    logic [i2cm_pkg::DATA_BITS-1:0] m_shift;
    logic                           m_ack_flag;
    logic                           m_mack;
    logic                           m_scl;
    logic                           m_sda;
    logic [i2cm_pkg::HOLD_W-1:0]    m_hold;

    job_t              engine_items[$];
    i2cm_pkg::result_t line_results_due[$];

    logic        in_took   = 1'b0;
    logic        cfg_took  = 1'b0;
    logic        calm      = 1'b0;
    logic        in_rush   = 1'b0;
    logic        out_rush  = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned stall_left = 0;
    int unsigned quiet     = 0;
    int unsigned cycles    = 0;

    int unsigned errors    = 0;
    int unsigned n_results = 0;
    int unsigned n_done    = 0;
    int unsigned n_refused = 0;
    int unsigned n_cfg     = 0;

    i2c_master_bit_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .tx_byte     (tx_byte),
        .send_ack    (send_ack),
        .sda_level   (sda_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_release (scl_release),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .ack_seen    (ack_seen),
        .read_byte   (read_byte),
        .refused     (refused),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void reset_engine();
        m_cmd      = i2cm_pkg::CMD_IDLE;
        m_period   = '0;
        m_ticks    = 0;
        m_shift    = '0;
        m_ack_flag = 1'b0;
        m_mack     = 1'b0;
        m_scl      = 1'b1;
        m_sda      = 1'b1;
        m_hold     = 16'd1;
    endfunction

    function automatic void set_lines();
        case (m_cmd)
            i2cm_pkg::CMD_START:
            begin
                m_scl = 1'b1;
                m_sda = (m_period == '0);
            end
            i2cm_pkg::CMD_STOP:
            begin
                m_scl = 1'b1;
                m_sda = (m_period != '0);
            end
            i2cm_pkg::CMD_WRITE:
            begin
                m_scl = ~m_period[0];
                m_sda = (m_period < 2 * i2cm_pkg::DATA_BITS)
                        ? m_shift[i2cm_pkg::DATA_BITS-1] : 1'b1;
            end
            i2cm_pkg::CMD_READ:
            begin
                m_scl = ~m_period[0];
                m_sda = (m_period < 2 * i2cm_pkg::DATA_BITS) ? 1'b1 : ~m_mack;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Advance the engine by one transaction and return the line state it leaves.
    function automatic i2cm_pkg::result_t engine_step(i2cm_pkg::item_t it);
        i2cm_pkg::result_t             r;
        int unsigned                   hold;
        int unsigned                   span;
        logic [i2cm_pkg::PERIOD_W-1:0] p;
        r = '0;
        if (it.kind >= i2cm_pkg::KIND_START && it.kind <= i2cm_pkg::KIND_READ)
        begin
            if (m_cmd != i2cm_pkg::CMD_IDLE)
            begin
                r.refused = 1'b1;
            end
            else
            begin
                case (it.kind)
                    i2cm_pkg::KIND_START: m_cmd = i2cm_pkg::CMD_START;
                    i2cm_pkg::KIND_STOP:  m_cmd = i2cm_pkg::CMD_STOP;
                    i2cm_pkg::KIND_WRITE: m_cmd = i2cm_pkg::CMD_WRITE;
                    default:              m_cmd = i2cm_pkg::CMD_READ;
                endcase
                m_period = '0;
                m_ticks  = 0;
                if (m_cmd == i2cm_pkg::CMD_WRITE)
                begin
                    m_shift    = it.tx_byte;
                    m_ack_flag = 1'b0;
                end
                else if (m_cmd == i2cm_pkg::CMD_READ)
                begin
                    m_shift = '0;
                    m_mack  = it.send_ack;
                end
                set_lines();
            end
        end
        else if (it.kind == i2cm_pkg::KIND_TICK && m_cmd != i2cm_pkg::CMD_IDLE)
        begin
            hold = (m_hold == '0) ? 1 : m_hold;
            m_ticks++;
            if (m_ticks >= hold)
            begin
                p       = m_period;
                m_ticks = 0;
                if (m_cmd == i2cm_pkg::CMD_WRITE)
                begin
                    if (p < 2 * i2cm_pkg::DATA_BITS && p[0])
                        m_shift = m_shift << 1;
                    if (p == 2 * i2cm_pkg::DATA_BITS)
                        m_ack_flag = ~it.sda_level;
                end
                else if (m_cmd == i2cm_pkg::CMD_READ)
                begin
                    if (p < 2 * i2cm_pkg::DATA_BITS && !p[0])
                        m_shift = {m_shift[i2cm_pkg::DATA_BITS-2:0], it.sda_level};
                end
                m_period = p + 1'b1;
                span = (m_cmd == i2cm_pkg::CMD_START || m_cmd == i2cm_pkg::CMD_STOP)
                       ? i2cm_pkg::CTRL_PERIODS : i2cm_pkg::BYTE_PERIODS;
                if (m_period >= span)
                begin
                    r.done_res = 1'b1;
                    if (m_cmd == i2cm_pkg::CMD_START)
                    begin
                        m_scl = 1'b0;
                        m_sda = 1'b0;
                    end
                    else if (m_cmd == i2cm_pkg::CMD_STOP)
                    begin
                        m_scl = 1'b1;
                        m_sda = 1'b1;
                    end
                    else
                    begin
                        m_scl = 1'b0;
                        if (m_cmd == i2cm_pkg::CMD_WRITE)
                            r.ack_seen = m_ack_flag;
                        else
                            r.read_byte = m_shift;
                    end
                    m_cmd    = i2cm_pkg::CMD_IDLE;
                    m_period = '0;
                end
                else
                begin
                    set_lines();
                end
            end
        end
        r.scl_release = m_scl;
        r.sda_release = m_sda;
        r.busy_res    = (m_cmd != i2cm_pkg::CMD_IDLE);
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none at all.
    function automatic int unsigned next_gap(inout logic rush);
        int unsigned r;
        if ($urandom_range(39) == 0)
            rush = ~rush;
        if (rush)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 87)
            return $urandom_range(1, 2);
        else if (r < 98)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic [2:0] k, input logic [7:0] tx, input logic sack,
                            input logic sda, input logic dense);
        job_t j;
        j.it.kind      = k;
        j.it.tx_byte   = tx;
        j.it.send_ack  = sack;
        j.it.sda_level = sda;
        j.is_cfg       = 1'b0;
        j.cfg_val      = '0;
        j.dense        = dense;
        engine_items.push_back(j);
    endtask

    task automatic add_random(input logic [2:0] k, input logic dense);
        add_item(k, 8'($urandom), 1'($urandom), 1'($urandom), dense);
    endtask

    task automatic add_cfg(input logic [15:0] v);
        job_t j;
        j.it      = '0;
        j.is_cfg  = 1'b1;
        j.cfg_val = v;
        j.dense   = 1'b0;
        engine_items.push_back(j);
    endtask

    // Mostly complete command sequences with random bus levels, plus refused
    // commands, spare kinds, idle ticks and sequences cut short.
    task automatic add_traffic(input int unsigned count, input int unsigned hold);
        int unsigned added;
        int unsigned pick;
        int unsigned span;
        int unsigned n;
        logic [2:0]  k;
        added = 0;
        if (hold == 0)
            hold = 1;
        while (added < count)
        begin
            pick = $urandom_range(99);
            k    = 3'($urandom_range(i2cm_pkg::KIND_START, i2cm_pkg::KIND_READ));
            span = (k == i2cm_pkg::KIND_START || k == i2cm_pkg::KIND_STOP)
                   ? i2cm_pkg::CTRL_PERIODS : i2cm_pkg::BYTE_PERIODS;
            if (pick < 90)
            begin
                add_random(k, 1'b0);
                n = (pick < 80) ? span * hold : $urandom_range(1, span * hold - 1);
                added++;
                repeat (n)
                begin
                    if ($urandom_range(99) < 6)
                    begin
                        add_random(3'($urandom_range(i2cm_pkg::KIND_START, KIND_LAST)), 1'b0);
                        added++;
                    end
                    add_random(i2cm_pkg::KIND_TICK, 1'b0);
                    added++;
                end
            end
            else
            begin
                add_random((pick < 95) ? i2cm_pkg::KIND_TICK
                                       : 3'($urandom_range(KIND_SPARE, KIND_LAST)),
                           1'b0);
            end
        end
        // finish whatever is still running before the next register write
        repeat (i2cm_pkg::BYTE_PERIODS * hold)
            add_random(i2cm_pkg::KIND_TICK, 1'b0);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] result %0d: %s got %0h want %0h", $time, n_results, what, got, want);
    endtask

    // feed input and register-write transactions
    always @(negedge clk)
    begin : feed
        logic v_next;
        logic c_next;
        job_t j;
        v_next = in_valid && !in_took;
        c_next = cfg_valid && !cfg_took;
        if (rst_n)
        begin
            if (!in_valid && !cfg_valid && line_results_due.size() == 0)
                quiet++;
            else
                quiet = 0;
            if (!v_next && !c_next && engine_items.size() != 0)
            begin
                if (engine_items[0].is_cfg)
                begin
                    // hold the write until the pipeline has drained
                    if (quiet >= SETTLE_CYCLES)
                    begin
                        j = engine_items.pop_front();
                        cfg_data <= j.cfg_val;
                        c_next = 1'b1;
                    end
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                end
                else
                begin
                    j = engine_items.pop_front();
                    kind      <= j.it.kind;
                    tx_byte   <= j.it.tx_byte;
                    send_ack  <= j.it.send_ack;
                    sda_level <= j.it.sda_level;
                    v_next    = 1'b1;
                    calm      = j.dense;
                    gap_left  = j.dense ? 0 : next_gap(in_rush);
                end
            end
        end
        in_valid  <= v_next;
        cfg_valid <= c_next;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n;
            if (!calm)
                stall_left = next_gap(out_rush);
        end
    end

    always @(posedge clk)
    begin : watch
        i2cm_pkg::result_t want;
        i2cm_pkg::result_t got;
        if (rst_n)
        begin
            in_took  <= in_valid && in_ready;
            cfg_took <= cfg_valid && cfg_ready;
            if (out_valid && out_ready)
            begin
                if (line_results_due.size() == 0)
                begin
                    report_mismatch("unexpected result", 8'h00, 8'h00);
                end
                else
                begin
                    want = line_results_due.pop_front();
                    got  = {scl_release, sda_release, busy_res, done_res, ack_seen,
                            read_byte, refused};
                    if (got.scl_release !== want.scl_release)
                        report_mismatch("scl_release", 8'(got.scl_release),
                                        8'(want.scl_release));
                    if (got.sda_release !== want.sda_release)
                        report_mismatch("sda_release", 8'(got.sda_release),
                                        8'(want.sda_release));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
                    if (got.ack_seen !== want.ack_seen)
                        report_mismatch("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", got.read_byte, want.read_byte);
                    if (got.refused !== want.refused)
                        report_mismatch("refused", 8'(got.refused), 8'(want.refused));
                    n_results++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                m_hold = cfg_data;
                n_cfg++;
            end
            if (in_valid && in_ready)
            begin
                want = engine_step('{kind, tx_byte, send_ack, sda_level});
                if (want.done_res)
                    n_done++;
                if (want.refused)
                    n_refused++;
                line_results_due.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned h;
        reset_engine();

        // idle tick and spare kinds do nothing
        add_item(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        add_item(KIND_LAST, 8'hFF, 1'b1, 1'b1, 1'b0);
        add_item(KIND_SPARE, 8'h5A, 1'b0, 1'b1, 1'b0);
        // start, with a command refused while it runs
        add_item(i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0, 1'b0);
        add_item(i2cm_pkg::KIND_READ, 8'hFF, 1'b1, 1'b1, 1'b0);
        repeat (i2cm_pkg::CTRL_PERIODS)
            add_item(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0);
        // write all ones, slave acks
        add_item(i2cm_pkg::KIND_WRITE, 8'hFF, 1'b0, 1'b1, 1'b0);
        repeat (i2cm_pkg::BYTE_PERIODS)
            add_item(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        // read all zeros, master nacks
        add_item(i2cm_pkg::KIND_READ, 8'h00, 1'b0, 1'b0, 1'b0);
        repeat (i2cm_pkg::BYTE_PERIODS)
            add_item(i2cm_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(i2cm_pkg::KIND_STOP, 8'h00, 1'b1, 1'b0, 1'b0);
        repeat (i2cm_pkg::CTRL_PERIODS)
            add_item(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1, 1'b0);

        add_traffic(120, 1);
        add_cfg(16'h0000);
        add_traffic(90, 1);
        add_cfg(16'h0002);
        add_traffic(100, 2);
        // longest period: a start held in its first period, back to back, then
        // the period shrinks below the ticks already counted
        add_cfg(HOLD_MAX);
        add_random(i2cm_pkg::KIND_START, 1'b1);
        for (int unsigned i = 0; i < LONG_TICKS; i++)
        begin
            if (i == LONG_TICKS / 2)
                add_random(i2cm_pkg::KIND_WRITE, 1'b1);
            add_random(i2cm_pkg::KIND_TICK, 1'b1);
        end
        add_cfg(16'h0001);
        repeat (i2cm_pkg::CTRL_PERIODS)
            add_random(i2cm_pkg::KIND_TICK, 1'b1);
        add_cfg(16'h0003);
        add_traffic(80, 3);
        h = $urandom_range(4, 6);
        add_cfg(16'(h));
        add_traffic(60, h);
        add_cfg(16'h0001);
        add_traffic(35, 1);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (engine_items.size() != 0 || in_valid || cfg_valid
               || line_results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d line results over %0d hold_ticks settings (0, 1 to 6, 65535).",
                 n_results, n_cfg + 1);
        $display("Commands completed: %0d, commands refused while busy: %0d.",
                 n_done, n_refused);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
